// ===== hdl/rar_pkg.sv =====
package rar_pkg;

	// default operand width and fixed result widths
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int NUM_W = 33;
	localparam int DEN_W = 31;

	// operation codes
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture operands, split into sign/magnitude
		logic mul0;      // raw denominator product
		logic mul1;      // first numerator product
		logic mul2;      // cross term for add/subtract
		logic sum;       // form raw numerator
		logic gcd_init;  // load binary gcd registers
		logic gcd_step;  // one gcd iteration
		logic div_step;  // one restoring division bit
		logic div_num;   // division running on the numerator
		logic fin;       // capture reduced result
		logic fin_err;   // capture the undefined result
	} rar_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic both_zero;
		logic gcd_done;
		logic div_last;
	} rar_sts_t;

endpackage

// ===== hdl/rar_ctrl.sv =====
module rar_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  rar_pkg::rar_sts_t sts,
	output rar_pkg::rar_cmd_t cmd
);
	import rar_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_MUL0  = 10'b00_0000_0010,
		S_MUL1  = 10'b00_0000_0100,
		S_MUL2  = 10'b00_0000_1000,
		S_SUM   = 10'b00_0001_0000,
		S_CHECK = 10'b00_0010_0000,
		S_GCD   = 10'b00_0100_0000,
		S_DIVN  = 10'b00_1000_0000,
		S_DIVD  = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} rar_state_t;

	rar_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.mul0  = 1'b1;
				state_nxt = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = S_SUM;
			end
			S_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (sts.both_zero) begin
					cmd.fin_err = 1'b1;
					state_nxt   = S_OUT;
				end else begin
					cmd.gcd_init = 1'b1;
					state_nxt    = S_GCD;
				end
			end
			S_GCD: begin
				cmd.gcd_step = 1'b1;
				if (sts.gcd_done) state_nxt = S_DIVN;
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				cmd.div_num  = 1'b1;
				if (sts.div_last) state_nxt = S_DIVD;
			end
			S_DIVD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.fin   = 1'b1;
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule

// ===== hdl/rar_dp.sv =====
module rar_dp #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                             clk,
	input  rar_pkg::rar_cmd_t                cmd,
	output rar_pkg::rar_sts_t                sts,
	input  logic [1:0]                       mode,
	input  logic signed [OPERAND_WIDTH-1:0]  a_num,
	input  logic signed [OPERAND_WIDTH-1:0]  a_den,
	input  logic signed [OPERAND_WIDTH-1:0]  b_num,
	input  logic signed [OPERAND_WIDTH-1:0]  b_den,
	output logic signed [rar_pkg::NUM_W-1:0] res_num,
	output logic [rar_pkg::DEN_W-1:0]        res_den,
	output logic                             undefined_result
);
	import rar_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = 2 * W;                    // magnitude width of intermediates
	localparam int CW = $clog2(MW);               // division bit counter
	localparam int KW = $clog2(MW + 1);           // common power of two in gcd
	localparam int XW = (MW > NUM_W) ? MW : NUM_W;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// operands as sign/magnitude
	logic [1:0]    mode_q;
	logic          an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [W-1:0]  an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;

	// products and raw pair
	logic          t1_neg_q, t2_neg_q, num_neg_q, den_neg_q;
	logic [MW-1:0] t1_mag_q, t2_mag_q, num_mag_q, den_mag_q;

	// gcd and division
	logic [MW-1:0] gx_q, gy_q, g_q;
	logic [KW-1:0] k_q;
	logic [MW-1:0] rem_q, quo_q, qn_q;
	logic [CW-1:0] cnt_q;

	// shared multiplier
	logic [W-1:0]  mul_a, mul_b;
	logic          mul_sa, mul_sb;
	logic [MW-1:0] prod;
	logic          prod_neg;

	always_comb begin
		mul_a  = an_mag_q;
		mul_sa = an_neg_q;
		mul_b  = bd_mag_q;
		mul_sb = bd_neg_q;
		if (cmd.mul0) begin
			mul_a  = ad_mag_q;
			mul_sa = ad_neg_q;
			if (mode_q == MODE_DIV) begin
				mul_b  = bn_mag_q;
				mul_sb = bn_neg_q;
			end
		end else if (cmd.mul2) begin
			mul_a  = bn_mag_q;
			mul_sa = bn_neg_q;
			mul_b  = ad_mag_q;
			mul_sb = ad_neg_q;
		end else if (mode_q == MODE_MUL) begin
			mul_b  = bn_mag_q;
			mul_sb = bn_neg_q;
		end
	end

	assign prod     = MW'(mul_a) * MW'(mul_b);
	assign prod_neg = (prod != '0) && (mul_sa ^ mul_sb);

	// signed-magnitude add of the two numerator terms
	logic [MW-1:0] sum_mag;
	logic          sum_neg;

	always_comb begin
		if (t1_neg_q == t2_neg_q) begin
			sum_mag = t1_mag_q + t2_mag_q;
			sum_neg = t1_neg_q;
		end else if (t1_mag_q >= t2_mag_q) begin
			sum_mag = t1_mag_q - t2_mag_q;
			sum_neg = t1_neg_q;
		end else begin
			sum_mag = t2_mag_q - t1_mag_q;
			sum_neg = t2_neg_q;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	// restoring division bit
	logic [MW:0]   div_sh, div_diff;
	logic          div_ge;
	logic [MW-1:0] rem_nxt, quo_nxt;

	assign div_sh   = {rem_q, quo_q[MW-1]};
	assign div_diff = div_sh - {1'b0, g_q};
	assign div_ge   = (div_sh >= {1'b0, g_q});
	assign rem_nxt  = div_ge ? div_diff[MW-1:0] : div_sh[MW-1:0];
	assign quo_nxt  = {quo_q[MW-2:0], div_ge};

	// result formatting
	logic          res_neg;
	logic [XW-1:0] qn_x, qd_x, rn_x;

	assign res_neg = (qn_q != '0) && (num_neg_q ^ den_neg_q);
	assign qn_x    = XW'(qn_q);
	assign qd_x    = XW'(quo_nxt);
	assign rn_x    = res_neg ? (~qn_x + 1'b1) : qn_x;

	assign sts.both_zero = (num_mag_q == '0) && (den_mag_q == '0);
	assign sts.gcd_done  = (gx_q == '0) || (gy_q == '0);
	assign sts.div_last  = (cnt_q == CW'(MW - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			an_neg_q <= a_num[W-1];
			ad_neg_q <= a_den[W-1];
			bn_neg_q <= b_num[W-1];
			bd_neg_q <= b_den[W-1];
			an_mag_q <= mag_of(a_num);
			ad_mag_q <= mag_of(a_den);
			bn_mag_q <= mag_of(b_num);
			bd_mag_q <= mag_of(b_den);
		end

		if (cmd.mul0) begin
			den_mag_q <= prod;
			den_neg_q <= prod_neg;
		end
		if (cmd.mul1) begin
			t1_mag_q <= prod;
			t1_neg_q <= prod_neg;
		end
		if (cmd.mul2) begin
			t2_mag_q <= prod;
			t2_neg_q <= (mode_q == MODE_SUB) ? ((prod != '0) && !prod_neg) : prod_neg;
		end

		if (cmd.sum) begin
			if ((mode_q == MODE_ADD) || (mode_q == MODE_SUB)) begin
				num_mag_q <= sum_mag;
				num_neg_q <= sum_neg;
			end else begin
				num_mag_q <= t1_mag_q;
				num_neg_q <= t1_neg_q;
			end
		end

		if (cmd.gcd_init) begin
			gx_q <= num_mag_q;
			gy_q <= den_mag_q;
			k_q  <= '0;
		end

		// binary gcd, one step a cycle
		if (cmd.gcd_step) begin
			if (gx_q == '0 || gy_q == '0) begin
				g_q   <= ((gx_q == '0) ? gy_q : gx_q) << k_q;
				rem_q <= '0;
				quo_q <= num_mag_q;
				cnt_q <= '0;
			end else if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				k_q  <= k_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q >= gy_q) begin
				gx_q <= (gx_q - gy_q) >> 1;
			end else begin
				gy_q <= (gy_q - gx_q) >> 1;
			end
		end

		if (cmd.div_step) begin
			if (sts.div_last) begin
				cnt_q <= '0;
				rem_q <= '0;
				if (cmd.div_num) begin
					qn_q  <= quo_nxt;
					quo_q <= den_mag_q;
				end
			end else begin
				cnt_q <= cnt_q + 1'b1;
				rem_q <= rem_nxt;
				quo_q <= quo_nxt;
			end
		end

		if (cmd.fin) begin
			res_num          <= $signed(rn_x[NUM_W-1:0]);
			res_den          <= qd_x[DEN_W-1:0];
			undefined_result <= 1'b0;
		end else if (cmd.fin_err) begin
			res_num          <= '0;
			res_den          <= '0;
			undefined_result <= 1'b1;
		end
	end

endmodule

// ===== hdl/rational_arith_reduce_unit.sv =====
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------------
// command   | start, busy             | mode, a_num, a_den, b_num, b_den
// result    | done (one-cycle strobe) | res_num, res_den, undefined_result
//
// A transaction is taken at a rising edge with start high and busy low.
// done pulses for one cycle once the gcd loop and the one-bit-per-cycle divider,
// run once for each of the two quotients, have finished.
// A transaction whose raw numerator and denominator are both zero skips them
// and strobes done with undefined_result set.
// busy stays high until done has been shown; arst_n clears the controller only.
// The receiver cannot stall: results are valid only in the done cycle.
module rational_arith_reduce_unit #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       mode,
	input  logic signed [OPERAND_WIDTH-1:0]  a_num,
	input  logic signed [OPERAND_WIDTH-1:0]  a_den,
	input  logic signed [OPERAND_WIDTH-1:0]  b_num,
	input  logic signed [OPERAND_WIDTH-1:0]  b_den,
	output logic                             done,
	output logic signed [rar_pkg::NUM_W-1:0] res_num,
	output logic [rar_pkg::DEN_W-1:0]        res_den,
	output logic                             undefined_result
);
	import rar_pkg::*;

	rar_cmd_t cmd;
	rar_sts_t sts;

	// sequencer: operand load, three shared multiplies, numerator sum,
	// zero check, gcd loop, two divisions, result strobe
	rar_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	// arithmetic: one W x W multiplier, binary gcd, restoring divider,
	// result registers that hold until the next transaction finishes
	rar_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk              (clk),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.a_num            (a_num),
		.a_den            (a_den),
		.b_num            (b_num),
		.b_den            (b_den),
		.res_num          (res_num),
		.res_den          (res_den),
		.undefined_result (undefined_result)
	);

	// an accepted transaction makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// result strobe lasts exactly one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// undefined result reads as zero over zero
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && undefined_result |-> (res_num == '0) && (res_den == '0))
		else $error("undefined result with nonzero payload");

	// a zero denominator leaves a unit numerator after reduction
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		done && !undefined_result && (res_den == '0) |->
			(res_num == 1) || (res_num == -1))
		else $error("zero denominator without unit numerator");

endmodule
